### rtl/ugr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugr_pkg
// Shared types and constants of the uniform grid linear resampler.
// ----------------------------------------------------------------------------
package ugr_pkg;

  localparam int SAMPLE_TIME_W = 32;
  localparam int GRID_TIME_W   = 48;
  localparam int VALUE_W       = 16;
  localparam int COUNT_W       = 20;
  localparam int GRID_INDEX_W  = 20;
  localparam int BURST_W       = 7;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 48;
  localparam int FRAC_W        = 16;

  localparam logic [GRID_TIME_W-1:0] GRID_TIME_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_START_TIME    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT  = 2'd2;

  typedef struct packed {
    logic [SAMPLE_TIME_W-1:0] sample_time;
    logic signed [VALUE_W-1:0] sample_value;
    logic                      final_sample;
  } ugr_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] grid_value;
    logic [GRID_INDEX_W-1:0]   grid_index;
    logic                      burst_end;
    logic                      burst_overflow;
  } ugr_out_t;

  // one burst of grid points handed from front to back
  typedef struct packed {
    logic [GRID_TIME_W-1:0]    ngt0;
    logic [GRID_INDEX_W-1:0]   idx0;
    logic [BURST_W-1:0]        n;
    logic [BURST_W-1:0]        ncov;
    logic                      ovf;
    logic [SAMPLE_TIME_W-1:0]  t0;
    logic [SAMPLE_TIME_W-1:0]  t1;
    logic signed [VALUE_W-1:0] v0;
    logic signed [VALUE_W-1:0] v1;
  } ugr_job_t;

  typedef struct packed {
    logic     valid;
    ugr_job_t job;
  } ugr_chan_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_DIV,
    F_CALC,
    F_MUL,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SETUP,
    B_DIV,
    B_ROUND,
    B_EMIT
  } back_state_e;

endpackage

### rtl/uniform_grid_linear_resampler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uniform_grid_linear_resampler_top
// Resamples timed samples onto a uniform grid by linear interpolation.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                word
//  cfg       in         cfg_we_i                 cfg_idx_i, cfg_wdata_i
//  in        in         in_valid_i / in_stall_o  ugr_in_t
//  out       out        out_valid_o / out_stall_i ugr_out_t
//
//  front takes a new sample only once it has pushed the last burst, after its serial
//  divide and shift-add grid advance; a final sample or zero period skips the advance
//  a burst waits in a 2-deep queue; back walks each interpolated point through setup,
//  16 divide steps, round and emit, other points through setup and emit, and pops in idle
//  reset is asynchronous and active low and clears all run state at once
//  out stall holds the output register; a full queue stalls the front
// ----------------------------------------------------------------------------
module uniform_grid_linear_resampler_top #(
  parameter int MAX_BURST       = 64,
  parameter int GRID_INDEX_BITS = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ugr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ugr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  ugr_pkg::ugr_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output ugr_pkg::ugr_out_t              out_data_o
);
  import ugr_pkg::*;

  logic [GRID_TIME_W-1:0] period;
  ugr_chan_t              push, head;
  logic                   full, pop;

  ugr_front #(
    .MAX_BURST      (MAX_BURST),
    .GRID_INDEX_BITS(GRID_INDEX_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .period_o   (period),
    .push_o     (push),
    .full_i     (full)
  );

  ugr_fifo u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .full_o(full),
    .head_o(head),
    .pop_i (pop)
  );

  ugr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .period_i   (period),
    .head_i     (head),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

### rtl/ugr_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugr_fifo
// Two-entry queue of bursts between the front and the back.
// ----------------------------------------------------------------------------
module ugr_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ugr_pkg::ugr_chan_t push_i,
  output logic              full_o,
  output ugr_pkg::ugr_chan_t head_o,
  input  logic              pop_i
);
  import ugr_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  ugr_job_t         mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o       = (cnt_q == FULL_CNT);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.job   = mem_q[rd_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.job;
    end
  end

endmodule

### rtl/ugr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugr_front
// Takes samples, keeps run state and registers, sizes each burst.
// ----------------------------------------------------------------------------
module ugr_front #(
  parameter int MAX_BURST       = 64,
  parameter int GRID_INDEX_BITS = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ugr_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ugr_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  ugr_pkg::ugr_in_t                    in_data_i,
  output logic [ugr_pkg::GRID_TIME_W-1:0]     period_o,
  output ugr_pkg::ugr_chan_t                  push_o,
  input  logic                                full_i
);
  import ugr_pkg::*;

  localparam int IDX_W = GRID_INDEX_BITS + 1;
  localparam int TOT_W = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;
  localparam int STEP_W = $clog2(IDX_W);
  localparam int DIV_W = GRID_TIME_W + IDX_W - 1;
  localparam int ACC_W = DIV_W + 2;
  localparam logic [TOT_W-1:0] RUN_CAP = TOT_W'(1) << GRID_INDEX_BITS;
  localparam logic [IDX_W:0] BURST_LIM = (IDX_W + 1)'(MAX_BURST);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(IDX_W - 1);

  front_state_e state_q, state_d;

  logic [SAMPLE_TIME_W-1:0] start_q, start_d;
  logic [GRID_TIME_W-1:0]   period_q, period_d;
  logic [COUNT_W-1:0]       count_q, count_d;
  logic [SAMPLE_TIME_W-1:0] prev_time_q, prev_time_d;
  logic signed [VALUE_W-1:0] prev_value_q, prev_value_d;
  logic                     have_prev_q, have_prev_d;
  logic [GRID_TIME_W-1:0]   ngt_q, ngt_d;
  logic [IDX_W-1:0]         idx_q, idx_d;

  logic                     fin_q, fin_d;
  logic                     none_q, none_d;
  logic                     sat_q, sat_d;
  logic [GRID_TIME_W-1:0]   div_r_q, div_r_d;
  logic [DIV_W-1:0]         div_s_q, div_s_d;
  logic [IDX_W-1:0]         quo_q, quo_d;
  logic [STEP_W-1:0]        step_q, step_d;
  logic [IDX_W-1:0]         due_q, due_d;
  logic [ACC_W-1:0]         acc_q, acc_d;
  logic [DIV_W-1:0]         add_q, add_d;
  logic [IDX_W-1:0]         mbits_q, mbits_d;
  ugr_job_t                 job_q, job_d;

  logic [GRID_TIME_W-1:0]   tnew_in, ngt_eff, diff_in;
  logic [DIV_W-1:0]         div_ext, div_left;
  logic                     div_ge;
  logic [TOT_W-1:0]         count_ext, total_w;
  logic [IDX_W-1:0]         total, rem, due;
  logic [IDX_W:0]           covered, rem_x, due_x, n_w, ncov_w;
  logic                     ovf_w;
  logic [ACC_W-1:0]         acc_add;
  logic [GRID_TIME_W-1:0]   acc_sat;
  logic                     done;

  assign period_o = period_q;

  // sample arriving
  assign tnew_in = {in_data_i.sample_time, FRAC_W'(0)};
  assign ngt_eff = (!have_prev_q && idx_q == '0) ? {start_q, FRAC_W'(0)} : ngt_q;
  assign diff_in = tnew_in - ngt_eff;

  // restoring divide step
  assign div_ext  = DIV_W'(div_r_q);
  assign div_ge   = (div_ext >= div_s_q);
  assign div_left = div_ext - div_s_q;

  // burst sizing
  assign count_ext = TOT_W'(count_q);
  assign total_w   = (count_ext >= RUN_CAP) ? RUN_CAP : count_ext;
  assign total     = total_w[IDX_W-1:0];
  assign rem       = (total > idx_q) ? total - idx_q : '0;
  assign rem_x     = {1'b0, rem};
  assign covered   = none_q ? '0 : (sat_q ? '1 : {1'b0, quo_q} + 1'b1);
  assign due       = (covered < rem_x) ? covered[IDX_W-1:0] : rem;
  assign due_x     = {1'b0, due};
  assign ncov_w    = (covered > BURST_LIM) ? BURST_LIM : covered;

  always_comb begin
    n_w   = '0;
    ovf_w = 1'b0;
    if (period_q != '0) begin
      if (fin_q) begin
        n_w   = (rem_x > BURST_LIM) ? BURST_LIM : rem_x;
        ovf_w = (rem_x > BURST_LIM);
      end else begin
        n_w   = (due_x > BURST_LIM) ? BURST_LIM : due_x;
        ovf_w = (due_x > BURST_LIM);
      end
    end
  end

  // grid advance by shift and add
  assign acc_add = acc_q + (mbits_q[0] ? {2'b00, add_q} : '0);
  assign acc_sat = (acc_add > ACC_W'(GRID_TIME_MAX)) ? GRID_TIME_MAX
                                                     : acc_add[GRID_TIME_W-1:0];

  assign done = (state_q == F_PUSH) && ((job_q.n == '0) || !full_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (in_valid_i) state_d = F_DIV;
      end
      F_DIV: begin
        if (step_q == '0) state_d = F_CALC;
      end
      F_CALC: begin
        state_d = (fin_q || period_q == '0) ? F_PUSH : F_MUL;
      end
      F_MUL: begin
        if (step_q == '0) state_d = F_PUSH;
      end
      F_PUSH: begin
        if (done) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o   = (state_q != F_IDLE);
    push_o.valid = (state_q == F_PUSH) && (job_q.n != '0) && !full_i;
    push_o.job   = job_q;
  end

  always_comb begin
    start_d      = start_q;
    period_d     = period_q;
    count_d      = count_q;
    prev_time_d  = prev_time_q;
    prev_value_d = prev_value_q;
    have_prev_d  = have_prev_q;
    ngt_d        = ngt_q;
    idx_d        = idx_q;
    fin_d        = fin_q;
    none_d       = none_q;
    sat_d        = sat_q;
    div_r_d      = div_r_q;
    div_s_d      = div_s_q;
    quo_d        = quo_q;
    step_d       = step_q;
    due_d        = due_q;
    acc_d        = acc_q;
    add_d        = add_q;
    mbits_d      = mbits_q;
    job_d        = job_q;
    case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          fin_d        = in_data_i.final_sample;
          job_d.t0     = have_prev_q ? prev_time_q : in_data_i.sample_time;
          job_d.v0     = have_prev_q ? prev_value_q : in_data_i.sample_value;
          job_d.t1     = in_data_i.sample_time;
          job_d.v1     = in_data_i.sample_value;
          job_d.ngt0   = ngt_eff;
          job_d.idx0   = GRID_INDEX_W'(idx_q);
          ngt_d        = ngt_eff;
          prev_time_d  = in_data_i.sample_time;
          prev_value_d = in_data_i.sample_value;
          have_prev_d  = 1'b1;
          none_d       = (ngt_eff > tnew_in);
          sat_d        = ((diff_in >> IDX_W) >= period_q);
          div_r_d      = diff_in;
          div_s_d      = DIV_W'(period_q) << (IDX_W - 1);
          quo_d        = '0;
          step_d       = LAST_STEP;
        end
      end
      F_DIV: begin
        if (div_ge) div_r_d = div_left[GRID_TIME_W-1:0];
        quo_d   = {quo_q[IDX_W-2:0], div_ge};
        div_s_d = div_s_q >> 1;
        step_d  = step_q - 1'b1;
      end
      F_CALC: begin
        job_d.n    = n_w[BURST_W-1:0];
        job_d.ncov = ncov_w[BURST_W-1:0];
        job_d.ovf  = ovf_w;
        due_d      = due;
        acc_d      = ACC_W'(ngt_q);
        add_d      = DIV_W'(period_q);
        mbits_d    = due;
        step_d     = LAST_STEP;
      end
      F_MUL: begin
        acc_d   = acc_add;
        add_d   = add_q << 1;
        mbits_d = mbits_q >> 1;
        step_d  = step_q - 1'b1;
        if (step_q == '0) begin
          ngt_d = acc_sat;
          idx_d = idx_q + due_q;
        end
      end
      F_PUSH: begin
        if (done && fin_q) begin
          have_prev_d = 1'b0;
          idx_d       = '0;
          ngt_d       = {start_q, FRAC_W'(0)};
        end
      end
      default: ;
    endcase
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_TIME: begin
          start_d = cfg_wdata_i[SAMPLE_TIME_W-1:0];
          if (!have_prev_q && idx_q == '0) begin
            ngt_d = {cfg_wdata_i[SAMPLE_TIME_W-1:0], FRAC_W'(0)};
          end
        end
        CFG_SAMPLE_PERIOD: period_d = cfg_wdata_i[GRID_TIME_W-1:0];
        CFG_OUTPUT_COUNT:  count_d  = cfg_wdata_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= F_IDLE;
      start_q      <= '0;
      period_q     <= '0;
      count_q      <= '0;
      prev_time_q  <= '0;
      prev_value_q <= '0;
      have_prev_q  <= 1'b0;
      ngt_q        <= '0;
      idx_q        <= '0;
    end else begin
      state_q      <= state_d;
      start_q      <= start_d;
      period_q     <= period_d;
      count_q      <= count_d;
      prev_time_q  <= prev_time_d;
      prev_value_q <= prev_value_d;
      have_prev_q  <= have_prev_d;
      ngt_q        <= ngt_d;
      idx_q        <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fin_q   <= fin_d;
    none_q  <= none_d;
    sat_q   <= sat_d;
    div_r_q <= div_r_d;
    div_s_q <= div_s_d;
    quo_q   <= quo_d;
    step_q  <= step_d;
    due_q   <= due_d;
    acc_q   <= acc_d;
    add_q   <= add_d;
    mbits_q <= mbits_d;
    job_q   <= job_d;
  end

endmodule

### rtl/ugr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugr_back
// Walks the grid points of each burst, interpolates and drives the output.
// ----------------------------------------------------------------------------
module ugr_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [ugr_pkg::GRID_TIME_W-1:0] period_i,
  input  ugr_pkg::ugr_chan_t              head_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output ugr_pkg::ugr_out_t               out_data_o
);
  import ugr_pkg::*;

  localparam int MAG_W = VALUE_W;
  localparam int BIT_W = $clog2(MAG_W);
  localparam int SUM_W = GRID_TIME_W + 2;
  localparam logic [BIT_W-1:0] TOP_BIT = BIT_W'(MAG_W - 1);

  back_state_e state_q, state_d;

  ugr_job_t                  job_q, job_d;
  logic [BURST_W-1:0]        k_q, k_d;
  logic [GRID_TIME_W-1:0]    tg_q, tg_d;
  logic [GRID_INDEX_W-1:0]   idx_q, idx_d;
  logic signed [VALUE_W-1:0] val_q, val_d;
  logic [GRID_TIME_W-1:0]    r_q, r_d;
  logic [GRID_TIME_W-1:0]    span_q, span_d;
  logic [GRID_TIME_W-1:0]    off_q, off_d;
  logic [MAG_W-1:0]          mag_q, mag_d;
  logic                      neg_q, neg_d;
  logic [MAG_W-1:0]          quo_q, quo_d;
  logic [BIT_W-1:0]          bit_q, bit_d;
  logic                      out_valid_q, out_valid_d;
  ugr_out_t                  out_q, out_d;

  logic [GRID_TIME_W-1:0]    t0w, t1w, span, off;
  logic [VALUE_W:0]          dv, dmag;
  logic                      covered, interp_go, last, load;
  logic [SUM_W-1:0]          tsum, span1, span2;
  logic [1:0]                digit;
  logic [SUM_W-1:0]          r_next;
  logic                      rnd;
  logic [MAG_W:0]            qf;
  logic [VALUE_W:0]          v0x, res;

  // segment setup
  assign t0w       = {job_q.t0, FRAC_W'(0)};
  assign t1w       = {job_q.t1, FRAC_W'(0)};
  assign span      = (t1w > t0w) ? t1w - t0w : '0;
  assign off       = (tg_q > t0w) ? tg_q - t0w : '0;
  assign dv        = {job_q.v1[VALUE_W-1], job_q.v1} - {job_q.v0[VALUE_W-1], job_q.v0};
  assign dmag      = dv[VALUE_W] ? (~dv + 1'b1) : dv;
  assign covered   = (k_q < job_q.ncov);
  assign interp_go = covered && (span != '0) && (off < span);

  // joint multiply and divide, one bit of the magnitude per cycle
  assign tsum  = {1'b0, r_q, 1'b0} + (mag_q[bit_q] ? {2'b00, off_q} : '0);
  assign span1 = {2'b00, span_q};
  assign span2 = {1'b0, span_q, 1'b0};

  always_comb begin
    if (tsum >= span2) begin
      digit  = 2'd2;
      r_next = tsum - span2;
    end else if (tsum >= span1) begin
      digit  = 2'd1;
      r_next = tsum - span1;
    end else begin
      digit  = 2'd0;
      r_next = tsum;
    end
  end

  // round half away from the previous value
  assign rnd = ({1'b0, r_q} + {2'b00, span_q[GRID_TIME_W-1:1]}) >= {1'b0, span_q};
  assign qf  = {1'b0, quo_q} + (MAG_W + 1)'(rnd);
  assign v0x = {job_q.v0[VALUE_W-1], job_q.v0};
  assign res = neg_q ? v0x - qf : v0x + qf;

  assign last = (k_q == job_q.n - 1'b1);
  assign load = (state_q == B_EMIT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (head_i.valid) state_d = B_SETUP;
      end
      B_SETUP: begin
        state_d = interp_go ? B_DIV : B_EMIT;
      end
      B_DIV: begin
        if (bit_q == '0) state_d = B_ROUND;
      end
      B_ROUND: begin
        state_d = B_EMIT;
      end
      B_EMIT: begin
        if (load) state_d = last ? B_IDLE : B_SETUP;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o       = (state_q == B_IDLE) && head_i.valid;
    out_valid_o = out_valid_q;
    out_data_o  = out_q;
  end

  always_comb begin
    job_d       = job_q;
    k_d         = k_q;
    tg_d        = tg_q;
    idx_d       = idx_q;
    val_d       = val_q;
    r_d         = r_q;
    span_d      = span_q;
    off_d       = off_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    quo_d       = quo_q;
    bit_d       = bit_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      B_IDLE: begin
        if (head_i.valid) begin
          job_d = head_i.job;
          k_d   = '0;
          tg_d  = head_i.job.ngt0;
          idx_d = head_i.job.idx0;
        end
      end
      B_SETUP: begin
        val_d  = (covered && span == '0) ? job_q.v0 : job_q.v1;
        r_d    = '0;
        quo_d  = '0;
        bit_d  = TOP_BIT;
        span_d = span;
        off_d  = off;
        mag_d  = dmag[MAG_W-1:0];
        neg_d  = dv[VALUE_W];
      end
      B_DIV: begin
        r_d   = r_next[GRID_TIME_W-1:0];
        quo_d = {quo_q[MAG_W-2:0], 1'b0} + MAG_W'(digit);
        bit_d = bit_q - 1'b1;
      end
      B_ROUND: begin
        val_d = res[VALUE_W-1:0];
      end
      B_EMIT: begin
        if (load) begin
          out_valid_d          = 1'b1;
          out_d.grid_value     = val_q;
          out_d.grid_index     = idx_q;
          out_d.burst_end      = last;
          out_d.burst_overflow = job_q.ovf;
          k_d                  = k_q + 1'b1;
          tg_d                 = tg_q + period_i;
          idx_d                = idx_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    k_q    <= k_d;
    tg_q   <= tg_d;
    idx_q  <= idx_d;
    val_q  <= val_d;
    r_q    <= r_d;
    span_q <= span_d;
    off_q  <= off_d;
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    quo_q  <= quo_d;
    bit_q  <= bit_d;
    out_q  <= out_d;
  end

  a_rem_below_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DIV) |-> (r_q < span_q))
    else $error("partial remainder not below span");

  a_step_within_segment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_ROUND) |-> (qf <= {1'b0, mag_q}))
    else $error("interpolation step beyond segment");

  a_point_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_EMIT) |-> (k_q < job_q.n))
    else $error("grid point beyond burst length");

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the uniform grid linear resampler. A queue of
// timed samples feeds a clocked driver; a clocked monitor compares every grid
// word against a bit-exact interpolation predictor. Directed runs cover value
// and time extremes, zero period and count, burst overflow, grid time
// saturation and backward time; random runs follow under several idling and
// stall mixes with register rewrites between phases.
// ----------------------------------------------------------------------------
module testbench;
  import ugr_pkg::*;

  localparam int          BURST_LIMIT   = 64;
  localparam int          SETTLE_CYCLES = 500;
  localparam int unsigned LIMIT         = 6_000_000;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  ugr_in_t               in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  ugr_out_t              out_data_o;

  uniform_grid_linear_resampler_top #(
    .MAX_BURST      (BURST_LIMIT),
    .GRID_INDEX_BITS(GRID_INDEX_W)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // predictor copy of registers and run state
  longint unsigned cfg_start;
  longint unsigned cfg_period;
  longint unsigned cfg_count;
  longint unsigned prev_time;
  int              prev_value;
  bit              have_prev;
  longint unsigned grid_time;
  longint unsigned grid_idx;

  ugr_in_t     sample_queue[$];
  ugr_out_t    due_points[$];
  ugr_out_t    next_point;
  int unsigned samples_queued   = 0;
  int unsigned samples_accepted = 0;
  int unsigned err_count        = 0;
  int unsigned cycle_count      = 0;
  int unsigned sender_idle_pct  = 0;
  int unsigned recv_stall_pct   = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void step_grid(input longint unsigned n);
    if (cfg_period == 0 || n == 0) return;
    if (n > (longint'(GRID_TIME_MAX) - grid_time) / cfg_period) begin
      grid_time = GRID_TIME_MAX;
    end else begin
      grid_time = grid_time + n * cfg_period;
    end
    grid_idx = grid_idx + n;
  endfunction

  function automatic int lerp(input longint unsigned target, input longint unsigned t0,
                              input longint unsigned span, input int v0, input int v1);
    longint unsigned off;
    longint unsigned mag;
    longint unsigned q;
    int              d;
    off = (target > t0) ? target - t0 : 0;
    if (span == 0) return v0;
    if (off >= span) return v1;
    d = v1 - v0;
    mag = (d < 0) ? -d : d;
    q = (mag * off + span / 2) / span;
    return (d < 0) ? v0 - int'(q) : v0 + int'(q);
  endfunction

  function automatic ugr_out_t grid_word(input int val);
    ugr_out_t w;
    w.grid_value     = val[VALUE_W-1:0];
    w.grid_index     = grid_idx[GRID_INDEX_W-1:0];
    w.burst_end      = 1'b0;
    w.burst_overflow = 1'b0;
    return w;
  endfunction

  function automatic void apply_config(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_START_TIME: begin
        cfg_start = data[SAMPLE_TIME_W-1:0];
        if (!have_prev && grid_idx == 0) grid_time = cfg_start << FRAC_W;
      end
      CFG_SAMPLE_PERIOD: cfg_period = data;
      CFG_OUTPUT_COUNT:  cfg_count  = data[COUNT_W-1:0];
      default: ;
    endcase
  endfunction

  // grid points due for one accepted sample
  function automatic void predict_grid_points(input ugr_in_t s);
    longint unsigned tnew;
    longint unsigned t0;
    longint unsigned span;
    longint unsigned rem;
    longint unsigned due;
    int              v1;
    int              count;
    bit              ovf;
    bit              done;
    ugr_out_t        burst[$];
    v1 = int'($signed(s.sample_value));
    if (!have_prev) begin
      prev_time  = s.sample_time;
      prev_value = v1;
      if (grid_idx == 0) grid_time = cfg_start << FRAC_W;
      have_prev = 1'b1;
    end
    tnew  = s.sample_time;
    tnew  = tnew << FRAC_W;
    t0    = prev_time << FRAC_W;
    span  = (tnew > t0) ? tnew - t0 : 0;
    count = 0;
    ovf   = 1'b0;
    if (cfg_period != 0) begin
      done = 1'b0;
      while (!done && grid_idx < cfg_count && grid_time <= tnew) begin
        if (count < BURST_LIMIT) begin
          burst.push_back(grid_word(lerp(grid_time, t0, span, prev_value, v1)));
          count++;
          step_grid(1);
        end else begin
          rem = cfg_count - grid_idx;
          due = (tnew - grid_time) / cfg_period + 1;
          step_grid((due < rem) ? due : rem);
          ovf  = 1'b1;
          done = 1'b1;
        end
      end
      if (s.final_sample) begin
        done = 1'b0;
        while (!done && grid_idx < cfg_count) begin
          if (count < BURST_LIMIT) begin
            burst.push_back(grid_word(v1));
            count++;
            step_grid(1);
          end else begin
            step_grid(cfg_count - grid_idx);
            ovf  = 1'b1;
            done = 1'b1;
          end
        end
      end
    end
    for (int k = 0; k < count; k++) begin
      burst[k].burst_overflow = ovf;
      burst[k].burst_end      = (k == count - 1);
      due_points.push_back(burst[k]);
    end
    prev_time  = s.sample_time;
    prev_value = v1;
    if (s.final_sample) begin
      have_prev = 1'b0;
      grid_idx  = 0;
      grid_time = cfg_start << FRAC_W;
    end
  endfunction

  // sample driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_grid_points(in_data_i);
        samples_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (sample_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_data_i  <= sample_queue.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // grid word monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_points.size() == 0) begin
        $error("unexpected grid word: grid_index %0d grid_value %0d",
               out_data_o.grid_index, $signed(out_data_o.grid_value));
        err_count++;
      end else begin
        next_point = due_points.pop_front();
        if (out_data_o.grid_value !== next_point.grid_value) begin
          $error("grid_value: expected %0d, actual %0d",
                 $signed(next_point.grid_value), $signed(out_data_o.grid_value));
          err_count++;
        end
        if (out_data_o.grid_index !== next_point.grid_index) begin
          $error("grid_index: expected %0d, actual %0d",
                 next_point.grid_index, out_data_o.grid_index);
          err_count++;
        end
        if (out_data_o.burst_end !== next_point.burst_end) begin
          $error("burst_end: expected %0b, actual %0b",
                 next_point.burst_end, out_data_o.burst_end);
          err_count++;
        end
        if (out_data_o.burst_overflow !== next_point.burst_overflow) begin
          $error("burst_overflow: expected %0b, actual %0b",
                 next_point.burst_overflow, out_data_o.burst_overflow);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    apply_config(idx, data);
  endtask

  task automatic set_config(input logic [SAMPLE_TIME_W-1:0] start,
                            input logic [GRID_TIME_W-1:0] period,
                            input logic [COUNT_W-1:0] count);
    write_reg(CFG_START_TIME, CFG_DATA_W'(start));
    write_reg(CFG_SAMPLE_PERIOD, CFG_DATA_W'(period));
    write_reg(CFG_OUTPUT_COUNT, CFG_DATA_W'(count));
  endtask

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin sender_idle_pct = 73; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin sender_idle_pct = 0;  recv_stall_pct = 73; end
      default:       begin sender_idle_pct = 32; recv_stall_pct = 32; end
    endcase
  endtask

  task automatic queue_sample(input longint unsigned t, input int v, input bit fin);
    ugr_in_t s;
    s.sample_time  = t[SAMPLE_TIME_W-1:0];
    s.sample_value = v[VALUE_W-1:0];
    s.final_sample = fin;
    sample_queue.push_back(s);
    samples_queued++;
  endtask

  // wait for every word, then let zero-result samples clear the pipeline
  task automatic drain_and_settle();
    while (samples_accepted != samples_queued || due_points.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // runs of nondecreasing samples around the grid, with noise and broken runs
  task automatic queue_random_phase(input int n_items, input longint unsigned pt);
    int              made;
    int              len;
    int unsigned     r;
    int              v;
    longint unsigned t;
    longint unsigned back;
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(99) < 10) begin
        queue_sample(longint'($urandom), int'($urandom), 1'($urandom_range(1)));
        made++;
      end else begin
        len  = $urandom_range(2, 8);
        back = $urandom_range(0, 32'(2 * pt));
        t    = (back > cfg_start) ? 0 : cfg_start - back;
        for (int k = 0; k < len; k++) begin
          r = $urandom_range(99);
          if (k == 0) begin
          end else if (r < 70) begin
            t = t + $urandom_range(0, 32'(3 * pt));
          end else if (r < 78) begin
            t = t + 100 * pt;
          end else if (r < 85) begin
            back = $urandom_range(1, 32'(2 * pt));
            t = (back > t) ? 0 : t - back;
          end
          if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
          if ($urandom_range(99) < 10) begin
            v = $urandom_range(1) ? 32767 : -32768;
          end else begin
            v = $urandom;
          end
          queue_sample(t, v, (k == len - 1) && ($urandom_range(9) != 0));
          made++;
        end
      end
    end
  endtask

  initial begin : main_seq
    longint unsigned          pt;
    logic [SAMPLE_TIME_W-1:0] st;
    logic [GRID_TIME_W-1:0]   per;
    logic [COUNT_W-1:0]       cnt;
    int unsigned              r;
    cfg_start  = 0;
    cfg_period = 0;
    cfg_count  = 0;
    prev_time  = 0;
    prev_value = 0;
    have_prev  = 1'b0;
    grid_time  = 0;
    grid_idx   = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_idling(IDLE_NONE);

    // first sample covers point 0, full-scale swing, span zero, backward time
    set_config(0, 48'h1_0000, 8);
    queue_sample(0, 32767, 0);
    queue_sample(4, -32768, 0);
    queue_sample(4, 100, 0);
    queue_sample(2, 5, 0);
    queue_sample(6, -1, 1);
    drain_and_settle();

    // zero period: nothing out, final still ends the run
    set_config(100, 0, 8);
    queue_sample(100, 1234, 0);
    queue_sample(200, -5, 0);
    queue_sample(300, 7, 1);
    drain_and_settle();

    // zero count
    set_config(100, 48'h1_0000, 0);
    queue_sample(150, 1, 0);
    queue_sample(160, 2, 1);
    drain_and_settle();

    // burst overflow on a big jump and on the final hold, high grid indexes
    set_config(0, 48'h1_0000, 20'hFFFFF);
    queue_sample(0, -32768, 0);
    queue_sample(1000000, 32767, 0);
    queue_sample(1000050, 0, 0);
    queue_sample(1000060, 16384, 1);
    drain_and_settle();

    // maximum period saturates grid time after point 0
    st = $urandom_range(0, 32'hFFFF_0000);
    set_config(st, GRID_TIME_MAX, 5);
    queue_sample(longint'(st), 10, 0);
    queue_sample(longint'(st + 32'd100), 20, 0);
    queue_sample(longint'(st + 32'd200), 30, 1);
    drain_and_settle();

    // latest start time, later points only on the final sample
    set_config(32'hFFFF_FFFF, 48'h1_0000, 3);
    queue_sample(32'hFFFF_FFF0, 5, 0);
    queue_sample(32'hFFFF_FFFF, -7, 0);
    queue_sample(32'hFFFF_FFFF, 9, 1);
    drain_and_settle();

    for (int p = 0; p < 8; p++) begin
      r  = $urandom_range(99);
      st = (r < 10) ? 32'h0 : (r < 20) ? 32'hFFFF_FFFF : $urandom;
      pt = $urandom_range(1, 200);
      r  = $urandom_range(99);
      per = (r < 5) ? '0 : GRID_TIME_W'((pt << FRAC_W) | $urandom_range(0, 16'hFFFF));
      r  = $urandom_range(99);
      cnt = (r < 15) ? 20'hFFFFF : (r < 30) ? COUNT_W'($urandom_range(0, 3))
                                            : COUNT_W'($urandom_range(4, 400));
      set_config(st, per, cnt);
      set_idling(idle_mode_e'(p % 4));
      queue_random_phase(20, pt);
      drain_and_settle();
    end

    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
